@@ rtl/em_cluster_trigger_decision_unit_macros.svh @@
// assertion macros for the em cluster trigger decision unit
// used by modules that check their own control; expects clk_i and rst_ni in scope
`ifndef EM_CLUSTER_TRIGGER_DECISION_UNIT_MACROS_SVH
`define EM_CLUSTER_TRIGGER_DECISION_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define EMCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define EMCT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/emct_pkg.sv @@
// shared types, constants and the 1/cosh table generator for the em cluster trigger
// no dependencies
package emct_pkg;

  localparam int unsigned ETA_W  = 14;
  localparam int unsigned PHI_W  = 13;
  localparam int unsigned E_W    = 25;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned INV_W  = 32;
  localparam int unsigned FRAC_W = 30;
  localparam int unsigned DLT_W  = 15;
  localparam int unsigned ETA_SPAN = 8192;

  typedef logic signed [DLT_W-1:0] delta_t;

  localparam delta_t PHI_PERIOD = 15'sd6283;
  localparam delta_t PHI_HALF   = 15'sd3141;
  localparam delta_t WIN_HALF   = 15'sd200;
  localparam delta_t CORE_HALF  = 15'sd100;

  // command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_CELL  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // cell classes
  localparam logic [1:0] CLS_EM  = 2'd0;
  localparam logic [1:0] CLS_HAD = 2'd1;

  // configuration register indexes
  localparam logic [1:0] REG_EM_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_EM_ISOLATION  = 2'd1;
  localparam logic [1:0] REG_HAD_ISOLATION = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEOM,
    S_MUL,
    S_RND,
    S_ACC,
    S_PAIR,
    S_MAX,
    S_OUT
  } emct_state_e;

  // where a cell's transverse energy goes
  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_Q0,
    TGT_Q1,
    TGT_Q2,
    TGT_Q3,
    TGT_RING,
    TGT_HAD
  } emct_tgt_e;

  typedef struct packed {
    logic begin_rgn;
    logic cell_load;
    logic geom;
    logic mul;
    logic rnd;
    logic acc;
    logic pair;
    logic pick;
    logic out_load;
  } emct_cmd_t;

  // unsigned long division by shift and subtract, used at elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(-r/1000) in q30 by a truncated 16 term series, r in 0..1000
  function automatic longint unsigned exp_frac(input longint unsigned r);
    longint unsigned x;
    longint unsigned term;
    longint sum;
    x    = udiv64(r << 30, 64'd1000);
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int unsigned n = 1; n <= 15; n++) begin
      term = udiv64(term * x, longint'(n) << 30);
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // 1/cosh(m/1000) in q30, evaluated at elaboration only
  function automatic logic [INV_W-1:0] inv_cosh_q30(input int unsigned m);
    longint unsigned e1;
    longint unsigned v;
    longint unsigned e2;
    longint unsigned q;
    longint unsigned whole;
    longint unsigned frac;
    e1    = exp_frac(64'd1000);
    whole = udiv64(longint'(m), 64'd1000);
    frac  = longint'(m) - whole * 64'd1000;
    v     = exp_frac(frac);
    for (longint unsigned k = 0; k < whole; k++) begin
      v = (v * e1) >> 30;
    end
    e2 = (v * v) >> 30;
    q  = udiv64((64'd2 * v) << 30, (64'd1 << 30) + e2);
    return q[INV_W-1:0];
  endfunction

endpackage

@@ rtl/em_cluster_trigger_decision_unit.sv @@
// top level of the em cluster trigger decision unit
// depends on emct_pkg, emct_ctrl and emct_dp
//
// Streams begin, cell and end requests for one 0.4 x 0.4 calorimeter window
// and returns one accept decision with the core pair, ring and hadronic sums
// on each end request. A begin request needs no further step. A cell request
// runs capture, 1/cosh rom read (registered), 25x32 multiply, rounding, and
// the saturating accumulate into at most one of six sums. An end request runs
// pair sums, maximum and cuts, plus any wait for the previous result to be
// taken; a finished result sits in the output register while the next
// requests are accepted. Configuration writes are registered, with no
// read-back; indexes past the three registers are dropped.
module em_cluster_trigger_decision_unit #(
  parameter int unsigned COSH_TABLE_DEPTH = 320,
  parameter int unsigned ACC_WIDTH        = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [emct_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         command_i,
  input  logic signed [emct_pkg::ETA_W-1:0]  eta_milli_i,
  input  logic [emct_pkg::PHI_W-1:0]         phi_milli_i,
  input  logic signed [emct_pkg::E_W-1:0]    energy_mev_i,
  input  logic [1:0]                         cell_class_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accept_o,
  output logic signed [emct_pkg::OUT_W-1:0]  max_pair_sum_o,
  output logic signed [emct_pkg::OUT_W-1:0]  ring_sum_o,
  output logic signed [emct_pkg::OUT_W-1:0]  hadronic_sum_o
);
  import emct_pkg::*;

  emct_cmd_t cmd;

  emct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  emct_dp #(
    .COSH_TABLE_DEPTH (COSH_TABLE_DEPTH),
    .ACC_WIDTH        (ACC_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .eta_milli_i    (eta_milli_i),
    .phi_milli_i    (phi_milli_i),
    .energy_mev_i   (energy_mev_i),
    .cell_class_i   (cell_class_i),
    .accept_o       (accept_o),
    .max_pair_sum_o (max_pair_sum_o),
    .ring_sum_o     (ring_sum_o),
    .hadronic_sum_o (hadronic_sum_o)
  );

endmodule

@@ rtl/emct_ctrl.sv @@
// sequencer for the em cluster trigger: input/output handshake and step commands
// depends on emct_pkg and the assertion macro header
`include "em_cluster_trigger_decision_unit_macros.svh"

module emct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output emct_pkg::emct_cmd_t cmd_o
);
  import emct_pkg::*;

  emct_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  logic [6:0]  step_vec;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_BEGIN: cmd_o.begin_rgn = 1'b1;
            CMD_CELL: begin
              cmd_o.cell_load = 1'b1;
              state_d         = S_GEOM;
            end
            CMD_END: state_d = S_PAIR;
            default: ;
          endcase
        end
      end
      S_GEOM: begin
        cmd_o.geom = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_IDLE;
      end
      S_PAIR: begin
        cmd_o.pair = 1'b1;
        state_d    = S_MAX;
      end
      S_MAX: begin
        cmd_o.pick = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        // hold until the previous result has been taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign step_vec = {cmd_o.geom, cmd_o.mul, cmd_o.rnd, cmd_o.acc,
                     cmd_o.pair, cmd_o.pick, cmd_o.out_load};

  `EMCT_ASSERT(a_out_slot_free, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `EMCT_ASSERT(a_cell_acc_timing, (in_acc && command_i == CMD_CELL) |-> ##4 cmd_o.acc, "cell not accumulated on time")
  `EMCT_ASSERT(a_one_step, $onehot0(step_vec), "more than one datapath step at once")
  `EMCT_ASSERT_NEXT(a_end_blocks_input, in_acc && command_i == CMD_END, !in_ready_o, "input taken during decision")

endmodule

@@ rtl/emct_dp.sv @@
// datapath for the em cluster trigger: cosh rom, et multiply, sums and decision
// depends on emct_pkg; steps are driven by emct_ctrl
module emct_dp #(
  parameter int unsigned COSH_TABLE_DEPTH = 320,
  parameter int unsigned ACC_WIDTH        = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  emct_pkg::emct_cmd_t                cmd_i,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [emct_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic signed [emct_pkg::ETA_W-1:0]  eta_milli_i,
  input  logic [emct_pkg::PHI_W-1:0]         phi_milli_i,
  input  logic signed [emct_pkg::E_W-1:0]    energy_mev_i,
  input  logic [1:0]                         cell_class_i,
  output logic                               accept_o,
  output logic signed [emct_pkg::OUT_W-1:0]  max_pair_sum_o,
  output logic signed [emct_pkg::OUT_W-1:0]  ring_sum_o,
  output logic signed [emct_pkg::OUT_W-1:0]  hadronic_sum_o
);
  import emct_pkg::*;

  localparam int unsigned IW   = $clog2(COSH_TABLE_DEPTH);
  localparam int unsigned DW   = $clog2(COSH_TABLE_DEPTH + 1);
  localparam int unsigned SCW  = ETA_W + DW;
  localparam int unsigned PW   = E_W + INV_W;
  localparam int unsigned ETW  = PW - FRAC_W;
  localparam int unsigned XW   = ((ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W) + 1;
  localparam logic signed [XW-1:0] ACC_MAX_X = XW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
  localparam logic signed [XW-1:0] ACC_MIN_X = ~ACC_MAX_X;
  localparam logic signed [XW-1:0] OUT_MAX_X = XW'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [XW-1:0] OUT_MIN_X = ~OUT_MAX_X;
  localparam logic [PW-1:0]        HALF_LSB  = PW'(1) << (FRAC_W - 1);

  typedef logic signed [ACC_WIDTH-1:0] acc_t;

  function automatic acc_t sat_acc(input logic signed [XW-1:0] v);
    if (v > ACC_MAX_X) return ACC_MAX_X[ACC_WIDTH-1:0];
    if (v < ACC_MIN_X) return ACC_MIN_X[ACC_WIDTH-1:0];
    return v[ACC_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [XW-1:0] v);
    if (v > OUT_MAX_X) return OUT_MAX_X[OUT_W-1:0];
    if (v < OUT_MIN_X) return OUT_MIN_X[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  // 1/cosh rom, entry i stands for the middle of its eta bin
  logic [INV_W-1:0] rom [COSH_TABLE_DEPTH];
  for (genvar g = 0; g < COSH_TABLE_DEPTH; g++) begin : g_rom
    localparam int unsigned M = ((2 * g + 1) * ETA_SPAN) / (2 * COSH_TABLE_DEPTH);
    localparam logic [INV_W-1:0] VAL = inv_cosh_q30(M);
    assign rom[g] = VAL;
  end

  // configuration
  logic [CFG_W-1:0] em_thr_q, em_iso_q, had_iso_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_thr_q  <= '0;
      em_iso_q  <= '1;
      had_iso_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EM_THRESHOLD:  em_thr_q  <= cfg_data_i;
        REG_EM_ISOLATION:  em_iso_q  <= cfg_data_i;
        REG_HAD_ISOLATION: had_iso_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // region center
  logic signed [ETA_W-1:0] ctr_eta_q;
  logic [PHI_W-1:0]        ctr_phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_eta_q <= '0;
      ctr_phi_q <= '0;
    end else if (cmd_i.begin_rgn) begin
      ctr_eta_q <= eta_milli_i;
      ctr_phi_q <= phi_milli_i;
    end
  end

  // cell request capture
  logic signed [ETA_W-1:0] eta_q;
  logic [PHI_W-1:0]        phi_q;
  logic signed [E_W-1:0]   energy_q;
  logic [1:0]              class_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_load) begin
      eta_q    <= eta_milli_i;
      phi_q    <= phi_milli_i;
      energy_q <= energy_mev_i;
      class_q  <= cell_class_i;
    end
  end

  // geometry step: deltas, phi wrap, table index and read
  delta_t          deta, dphi_raw, dphi;
  logic [ETA_W-1:0] aeta;
  logic [SCW-1:0]  scaled, scaled_sh;
  logic [IW-1:0]   idx;
  logic [E_W-1:0]  mag;

  assign deta     = DLT_W'(eta_q) - DLT_W'(ctr_eta_q);
  assign dphi_raw = $signed(DLT_W'(phi_q)) - $signed(DLT_W'(ctr_phi_q));

  always_comb begin
    if (dphi_raw > PHI_HALF) dphi = dphi_raw - PHI_PERIOD;
    else if (dphi_raw < -PHI_HALF) dphi = dphi_raw + PHI_PERIOD;
    else dphi = dphi_raw;
  end

  assign aeta      = eta_q[ETA_W-1] ? ETA_W'(-eta_q) : ETA_W'(eta_q);
  assign scaled    = SCW'(aeta) * SCW'(COSH_TABLE_DEPTH);
  assign scaled_sh = scaled >> 13;
  assign idx       = (scaled_sh >= SCW'(COSH_TABLE_DEPTH)) ? IW'(COSH_TABLE_DEPTH - 1)
                                                           : scaled_sh[IW-1:0];
  assign mag       = energy_q[E_W-1] ? E_W'(-energy_q) : E_W'(energy_q);

  delta_t           deta_q, dphi_q;
  logic [E_W-1:0]   mag_q;
  logic             neg_q;
  logic [INV_W-1:0] rom_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.geom) begin
      deta_q <= deta;
      dphi_q <= dphi;
      mag_q  <= mag;
      neg_q  <= energy_q[E_W-1];
      rom_q  <= rom[idx];
    end
  end

  // multiply step, with window and quadrant classification alongside
  emct_tgt_e tgt, tgt_q;
  logic      in_win, eta_lo, eta_hi, phi_lo, phi_hi;
  logic [PW-1:0] prod_q;

  assign in_win = (deta_q > -WIN_HALF) && (deta_q < WIN_HALF) &&
                  (dphi_q > -WIN_HALF) && (dphi_q < WIN_HALF);
  assign eta_lo = (deta_q < 0) && (deta_q > -CORE_HALF);
  assign eta_hi = (deta_q > 0) && (deta_q < CORE_HALF);
  assign phi_hi = (dphi_q > 0) && (dphi_q < CORE_HALF);
  assign phi_lo = (dphi_q < 0) && (dphi_q > -CORE_HALF);

  always_comb begin
    tgt = TGT_NONE;
    if (in_win && class_q == CLS_EM) begin
      if (eta_lo && phi_hi) tgt = TGT_Q0;
      else if (eta_hi && phi_hi) tgt = TGT_Q1;
      else if (eta_lo && phi_lo) tgt = TGT_Q2;
      else if (eta_hi && phi_lo) tgt = TGT_Q3;
      else tgt = TGT_RING;
    end else if (in_win && class_q == CLS_HAD) begin
      tgt = TGT_HAD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PW'(mag_q) * PW'(rom_q);
      tgt_q  <= tgt;
    end
  end

  // rounding step, half away from zero
  logic [PW-1:0]            prod_rnd;
  logic signed [ETW-1:0]    et_mag;
  logic signed [ETW-1:0]    et_q;

  assign prod_rnd = prod_q + HALF_LSB;
  assign et_mag   = $signed(prod_rnd[PW-1:FRAC_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) et_q <= neg_q ? -et_mag : et_mag;
  end

  // saturating accumulators
  acc_t quad_q [4];
  acc_t ring_q, had_q;
  logic seen_q;
  acc_t acc_sel, acc_sum;

  always_comb begin
    case (tgt_q)
      TGT_Q0:   acc_sel = quad_q[0];
      TGT_Q1:   acc_sel = quad_q[1];
      TGT_Q2:   acc_sel = quad_q[2];
      TGT_Q3:   acc_sel = quad_q[3];
      TGT_RING: acc_sel = ring_q;
      TGT_HAD:  acc_sel = had_q;
      default:  acc_sel = '0;
    endcase
  end

  assign acc_sum = sat_acc(XW'(acc_sel) + XW'(et_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= '{default: '0};
      ring_q <= '0;
      had_q  <= '0;
    end else if (cmd_i.begin_rgn || cmd_i.out_load) begin
      quad_q <= '{default: '0};
      ring_q <= '0;
      had_q  <= '0;
    end else if (cmd_i.acc) begin
      case (tgt_q)
        TGT_Q0:   quad_q[0] <= acc_sum;
        TGT_Q1:   quad_q[1] <= acc_sum;
        TGT_Q2:   quad_q[2] <= acc_sum;
        TGT_Q3:   quad_q[3] <= acc_sum;
        TGT_RING: ring_q    <= acc_sum;
        TGT_HAD:  had_q     <= acc_sum;
        default: ;
      endcase
    end
  end

  // any cell, even an ignored one, marks the region as populated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seen_q <= 1'b0;
    else if (cmd_i.begin_rgn || cmd_i.out_load) seen_q <= 1'b0;
    else if (cmd_i.cell_load) seen_q <= 1'b1;
  end

  // decision: pair sums, then max, then cuts
  acc_t pair_q [4];
  acc_t max_q;
  acc_t max_lr, max_tb;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pair) begin
      pair_q[0] <= sat_acc(XW'(quad_q[0]) + XW'(quad_q[2]));
      pair_q[1] <= sat_acc(XW'(quad_q[1]) + XW'(quad_q[3]));
      pair_q[2] <= sat_acc(XW'(quad_q[0]) + XW'(quad_q[1]));
      pair_q[3] <= sat_acc(XW'(quad_q[2]) + XW'(quad_q[3]));
    end
  end

  assign max_lr = (pair_q[1] > pair_q[0]) ? pair_q[1] : pair_q[0];
  assign max_tb = (pair_q[3] > pair_q[2]) ? pair_q[3] : pair_q[2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) max_q <= (max_tb > max_lr) ? max_tb : max_lr;
  end

  logic signed [XW-1:0] max_x, ring_x, had_x, thr_x, eiso_x, hiso_x;
  logic                 pass;

  assign max_x  = XW'(max_q);
  assign ring_x = XW'(ring_q);
  assign had_x  = XW'(had_q);
  assign thr_x  = XW'(em_thr_q);
  assign eiso_x = XW'(em_iso_q);
  assign hiso_x = XW'(had_iso_q);
  assign pass   = seen_q && (max_x > thr_x) && (ring_x < eiso_x) && (had_x < hiso_x);

  logic                    res_accept_q;
  logic signed [OUT_W-1:0] res_max_q, res_ring_q, res_had_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_accept_q <= pass;
      res_max_q    <= sat_out(max_x);
      res_ring_q   <= sat_out(ring_x);
      res_had_q    <= sat_out(had_x);
    end
  end

  assign accept_o       = res_accept_q;
  assign max_pair_sum_o = res_max_q;
  assign ring_sum_o     = res_ring_q;
  assign hadronic_sum_o = res_had_q;

endmodule
